[rtl/dfb_pkg.sv]
// Shared constants, stream widths, action codes and controller/datapath links
// for the display frame buffer. No dependencies.
`default_nettype none
package dfb_pkg;

    localparam int PAGE_COUNT   = 8;
    localparam int COLUMN_COUNT = 128;
    localparam int STORE_SIZE   = PAGE_COUNT * COLUMN_COUNT;
    localparam int LINE_COUNT   = PAGE_COUNT * 8;

    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMN_COUNT);
    localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Input and output stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_AND      = 3'd1,
        ACT_OR       = 3'd2,
        ACT_PIXEL    = 3'd3,
        ACT_CLR_PAGE = 3'd4,
        ACT_ROTATE   = 3'd5,
        ACT_CLR_ALL  = 3'd6,
        ACT_DRAIN    = 3'd7
    } dfb_action_t;

    typedef struct packed {
        logic capture;     // take the input item and issue its first read
        logic cnt_inc;     // advance the sweep counter
        logic sweep_zero;  // write zero at the sweep address
        logic sweep_all;   // sweep covers the whole store, not one page
        logic rot_step;    // one step of the page rotation
        logic rot_last;    // write the saved first byte to the last column
        logic finish;      // apply the item's update and load the result
    } dfb_cmd_t;

    typedef struct packed {
        logic cnt_page_last;
        logic cnt_all_last;
        logic out_free;
    } dfb_status_t;

endpackage
`default_nettype wire

[rtl/dfb_ctrl.sv]
// Sequencing state machine for the display frame buffer: reset clearing
// pass, byte operations, page sweeps and rotation. Uses dfb_pkg.
`default_nettype none
module dfb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire dfb_pkg::dfb_action_t in_action,
    output logic                      in_ready,
    input  wire dfb_pkg::dfb_status_t status,
    output dfb_pkg::dfb_cmd_t         cmd
);
    import dfb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLR_PAGE,
        S_CLR_ALL,
        S_ROT,
        S_ROT_LAST,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_zero = 1'b1;
                cmd.sweep_all  = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (status.cnt_all_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_action)
                        ACT_CLR_PAGE: state_next = S_CLR_PAGE;
                        ACT_ROTATE:   state_next = S_ROT;
                        ACT_CLR_ALL:  state_next = S_CLR_ALL;
                        default:      state_next = S_FINISH;
                    endcase
                end
            end
            S_CLR_PAGE:
            begin
                cmd.sweep_zero = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (status.cnt_page_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLR_ALL:
            begin
                cmd.sweep_zero = 1'b1;
                cmd.sweep_all  = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (status.cnt_all_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_page_last)
                begin
                    state_next = S_ROT_LAST;
                end
            end
            S_ROT_LAST:
            begin
                cmd.rot_last = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/dfb_datapath.sv]
// Frame memory, item register, dirty bits, drain position and result
// register of the display frame buffer. Uses dfb_pkg.
`default_nettype none
module dfb_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dfb_pkg::dfb_cmd_t              cmd,
    output dfb_pkg::dfb_status_t                status,
    input  wire logic [dfb_pkg::IN_TDATA_W-1:0] in_tdata,
    input  wire logic [dfb_pkg::IN_TUSER_W-1:0] in_tuser,
    output logic                                out_tvalid,
    input  wire logic                           out_tready,
    output logic [dfb_pkg::OUT_TDATA_W-1:0]     out_tdata,
    output logic [dfb_pkg::OUT_TUSER_W-1:0]     out_tuser,
    output logic                                out_tlast
);
    import dfb_pkg::*;

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [2:0] pg, input int col);
        return ADDR_W'(int'(pg) * COLUMN_COUNT + col);
    endfunction

    function automatic logic pixel_ok(input logic [15:0] px, input logic [15:0] py);
        return !px[15] && (int'(px) < COLUMN_COUNT) && !py[15] && (int'(py) < LINE_COUNT);
    endfunction

    logic [7:0] store_mem [STORE_SIZE];
    logic [7:0] rd_data_reg;

    // captured item
    dfb_action_t act_reg;
    logic [2:0]  page_reg;
    logic [6:0]  col_reg;
    logic [7:0]  data_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [7:0]  first_reg;

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [PAGE_COUNT-1:0] dirty_reg;
    logic [PAGE_COUNT-1:0] dirty_next;
    logic [PG_W-1:0]       drain_page_reg;
    logic [PG_W-1:0]       drain_page_next;
    logic [COL_W-1:0]      drain_col_reg;
    logic [COL_W-1:0]      drain_col_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                   out_last_reg;

    // input fields
    dfb_action_t in_act;
    logic [2:0]  in_page;
    logic [6:0]  in_col;
    logic [15:0] in_x;
    logic [15:0] in_y;

    assign in_act  = dfb_action_t'(in_tuser);
    assign in_page = in_tdata[2:0];
    assign in_col  = in_tdata[9:3];
    assign in_x    = in_tdata[33:18];
    assign in_y    = in_tdata[49:34];

    // drain position
    logic             drain_start;
    logic             drain_active;
    logic [PG_W-1:0]  low_page;
    logic [PG_W-1:0]  dp;
    logic [COL_W-1:0] dc;
    logic             dc_last;

    always_comb
    begin
        low_page = '0;
        for (int i = PAGE_COUNT - 1; i >= 0; i--)
        begin
            if (dirty_reg[i])
            begin
                low_page = PG_W'(i);
            end
        end
    end

    assign drain_start  = !busy_reg && (|dirty_reg);
    assign drain_active = drain_start || busy_reg;
    assign dp           = drain_start ? low_page : drain_page_reg;
    assign dc           = drain_start ? '0 : drain_col_reg;
    assign dc_last      = (dc == COL_W'(COLUMN_COUNT - 1));

    // item checks
    logic page_ok;
    logic byte_ok;
    logic pix_ok;
    logic [2:0] pix_page;

    assign page_ok  = int'(page_reg) < PAGE_COUNT;
    assign byte_ok  = page_ok && (int'(col_reg) < COLUMN_COUNT);
    assign pix_ok   = pixel_ok(x_reg, y_reg);
    assign pix_page = y_reg[5:3];

    assign status.cnt_page_last = (cnt_reg == CNT_W'(COLUMN_COUNT - 1));
    assign status.cnt_all_last  = (cnt_reg == CNT_W'(STORE_SIZE - 1));
    assign status.out_free      = !out_valid_reg || out_tready;

    // memory addressing
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        mod_data;
    logic [ADDR_W-1:0] item_addr;

    assign item_addr = (act_reg == ACT_PIXEL)
                     ? byte_addr(pix_page, int'(x_reg[7:0]))
                     : byte_addr(page_reg, int'(col_reg));

    always_comb
    begin
        case (act_reg)
            ACT_WRITE: mod_data = data_reg;
            ACT_AND:   mod_data = rd_data_reg & data_reg;
            ACT_OR:    mod_data = rd_data_reg | data_reg;
            default:   mod_data = rd_data_reg | (8'd1 << y_reg[2:0]);
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.capture)
        begin
            rd_en = 1'b1;
            case (in_act)
                ACT_PIXEL:  rd_addr = byte_addr(in_y[5:3], int'(in_x[7:0]));
                ACT_ROTATE: rd_addr = byte_addr(in_page, 0);
                ACT_DRAIN:  rd_addr = ADDR_W'(int'(dp) * COLUMN_COUNT + int'(dc));
                default:    rd_addr = byte_addr(in_page, int'(in_col));
            endcase
        end
        else if (cmd.rot_step)
        begin
            rd_en   = !status.cnt_page_last;
            rd_addr = byte_addr(page_reg, int'(cnt_reg) + 1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.sweep_zero)
        begin
            wr_en   = cmd.sweep_all || page_ok;
            wr_addr = cmd.sweep_all ? cnt_reg[ADDR_W-1:0] : byte_addr(page_reg, int'(cnt_reg));
        end
        else if (cmd.rot_step)
        begin
            // shift the byte just read one column left
            wr_en   = page_ok && (cnt_reg != '0);
            wr_addr = byte_addr(page_reg, int'(cnt_reg) - 1);
            wr_data = rd_data_reg;
        end
        else if (cmd.rot_last)
        begin
            wr_en   = page_ok;
            wr_addr = byte_addr(page_reg, COLUMN_COUNT - 1);
            wr_data = first_reg;
        end
        else if (cmd.finish)
        begin
            wr_addr = item_addr;
            wr_data = mod_data;
            case (act_reg)
                ACT_WRITE, ACT_AND, ACT_OR: wr_en = byte_ok;
                ACT_PIXEL:                  wr_en = pix_ok;
                default:                    wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // item and rotation payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= in_act;
            page_reg <= in_page;
            col_reg  <= in_col;
            data_reg <= in_tdata[17:10];
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
        if (cmd.rot_step && (cnt_reg == '0))
        begin
            first_reg <= rd_data_reg;
        end
    end

    // control state and result
    logic       res_valid;
    logic       res_done;
    logic       res_acc;
    logic [7:0] res_byte;

    always_comb
    begin
        cnt_next        = cnt_reg;
        dirty_next      = dirty_reg;
        drain_page_next = drain_page_reg;
        drain_col_next  = drain_col_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !out_tready;
        res_valid       = 1'b0;
        res_done        = 1'b0;
        res_acc         = 1'b1;
        res_byte        = '0;

        if (cmd.capture)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            case (act_reg)
                ACT_WRITE, ACT_AND, ACT_OR:
                begin
                    if (byte_ok)
                    begin
                        dirty_next[page_reg[PG_W-1:0]] = 1'b1;
                    end
                end
                ACT_PIXEL:
                begin
                    res_acc = pix_ok;
                    if (pix_ok)
                    begin
                        dirty_next[pix_page[PG_W-1:0]] = 1'b1;
                    end
                end
                ACT_CLR_PAGE, ACT_ROTATE:
                begin
                    if (page_ok)
                    begin
                        dirty_next[page_reg[PG_W-1:0]] = 1'b1;
                    end
                end
                ACT_CLR_ALL:
                begin
                    dirty_next = '1;
                end
                default:
                begin
                    if (drain_active)
                    begin
                        res_valid       = 1'b1;
                        res_byte        = rd_data_reg;
                        drain_page_next = dp;
                        if (dc_last)
                        begin
                            res_done       = 1'b1;
                            dirty_next[dp] = 1'b0;
                            busy_next      = 1'b0;
                            drain_col_next = '0;
                        end
                        else
                        begin
                            busy_next      = 1'b1;
                            drain_col_next = dc + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            dirty_reg      <= '0;
            drain_page_reg <= '0;
            drain_col_reg  <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            dirty_reg      <= dirty_next;
            drain_page_reg <= drain_page_next;
            drain_col_reg  <= drain_col_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {6'd0, res_byte,
                             res_valid ? 7'(dc) : 7'd0,
                             res_valid ? 3'(dp) : 3'd0};
            out_user_reg <= {res_acc, res_valid};
            out_last_reg <= res_done;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tuser  = out_user_reg;
    assign out_tlast  = out_last_reg;

endmodule
`default_nettype wire

[rtl/display_frame_buffer_dirty_pages_top.sv]
// Byte, pixel, page and drain operations pass through a finish state that waits for a free
// result register; no new item is accepted before then. Clear page sweeps COLUMN_COUNT
// entries, rotate page steps over COLUMN_COUNT columns and then writes the last column,
// clear all sweeps STORE_SIZE entries: one frame memory write port, one entry a cycle.
// Reset: asynchronous, active low; afterward a clearing pass over all STORE_SIZE (1024)
// entries zeroes the frame memory with s_axis_tready low. Depends on dfb_pkg, dfb_ctrl, dfb_datapath.
`default_nettype none
module display_frame_buffer_dirty_pages_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // page[2:0], column[9:3], data[17:10], x[33:18], y[49:34], zero fill
    input  wire logic [dfb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // action[2:0]
    input  wire logic [dfb_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_page[2:0], out_column[9:3], out_byte[17:10], zero fill
    output logic [dfb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // byte_valid[0], accepted[1]
    output logic [dfb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // page_done
    output logic                                m_axis_tlast
);
    import dfb_pkg::*;

    dfb_cmd_t    cmd;
    dfb_status_t status;

    dfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (dfb_action_t'(s_axis_tuser)),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dfb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .out_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
